// File: rtl/slofr_pkg.sv
package slofr_pkg;

	localparam int HEADER_BYTES = 6;
	localparam int MAX_SLOTS    = 6;

	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t REG_ENABLE_MASK = 3'd6;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_SUM_GOOD = 2'd1,
		KIND_SUM_BAD = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic [15:0] frame_opcode;
		logic [15:0] frame_length;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [MAX_SLOTS-1:0][15:0] opcode;
		logic [MAX_SLOTS-1:0]       enable;
	} opcode_tbl_t;

endpackage

// File: rtl/slofr_if.sv
interface slofr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface slofr_result_if;
	import slofr_pkg::*;
	logic        valid;
	logic        ready;
	kind_t       kind;
	logic [7:0]  payload_byte;
	logic [15:0] byte_index;
	logic [15:0] frame_opcode;
	logic [15:0] frame_length;
	logic        last;

	modport source (output valid, output kind, output payload_byte, output byte_index,
		output frame_opcode, output frame_length, output last, input ready);
	modport sink (input valid, input kind, input payload_byte, input byte_index,
		input frame_opcode, input frame_length, input last, output ready);
endinterface

interface slofr_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/slofr_cfg.sv
module slofr_cfg #(
	parameter int OPCODE_SLOTS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	slofr_cfg_if.sink             cfg,
	output slofr_pkg::opcode_tbl_t tbl
);
	import slofr_pkg::*;

	localparam logic [MAX_SLOTS-1:0] SlotMask = MAX_SLOTS'((1 << OPCODE_SLOTS) - 1);

	logic [MAX_SLOTS-1:0] mask_q;
	logic                 wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (wr && cfg.index == REG_ENABLE_MASK) begin
			mask_q <= cfg.data[MAX_SLOTS-1:0];
		end
	end

	for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_slot
		if (g < OPCODE_SLOTS) begin : g_used
			logic [15:0] op_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					op_q <= '0;
				end else if (wr && cfg.index == cfg_idx_t'(g)) begin
					op_q <= cfg.data;
				end
			end

			assign tbl.opcode[g] = op_q;
		end else begin : g_absent
			assign tbl.opcode[g] = '0;
		end
	end

	assign tbl.enable = mask_q & SlotMask;

endmodule

// File: rtl/slofr_parser.sv
module slofr_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             byte_in,
	input  slofr_pkg::opcode_tbl_t tbl,
	output logic                   res_valid,
	output slofr_pkg::result_t     res
);
	import slofr_pkg::*;

	localparam int WinDepth = HEADER_BYTES - 1;

	logic [7:0]  win_q [WinDepth];
	logic [2:0]  fill_q;
	logic        in_payload_q;
	logic [15:0] remain_q;
	logic [15:0] pos_q;
	logic [7:0]  sum_q;
	logic [15:0] len_q;
	logic [15:0] op_q;

	logic                 hdr_done;
	logic [15:0]          hdr_len;
	logic [15:0]          hdr_op;
	logic [MAX_SLOTS-1:0] slot_hit;
	logic                 hdr_ok;
	logic [7:0]           hdr_sum;

	assign hdr_done = !in_payload_q && fill_q == 3'(WinDepth);
	assign hdr_len  = {win_q[2], win_q[3]};
	assign hdr_op   = {win_q[4], byte_in};
	assign hdr_sum  = win_q[2] + win_q[3] + win_q[4] + byte_in;

	always_comb begin
		for (int i = 0; i < MAX_SLOTS; i++) begin
			slot_hit[i] = tbl.enable[i] && tbl.opcode[i] == hdr_op;
		end
	end

	assign hdr_ok = win_q[0] == SYNC_FIRST && win_q[1] == SYNC_SECOND && |slot_hit;

	always_comb begin
		res_valid        = in_payload_q;
		res.frame_opcode = op_q;
		res.frame_length = len_q;
		if (remain_q != '0) begin
			res.kind         = KIND_PAYLOAD;
			res.payload_byte = byte_in;
			res.byte_index   = pos_q;
			res.last         = 1'b0;
		end else begin
			res.kind         = (byte_in == sum_q) ? KIND_SUM_GOOD : KIND_SUM_BAD;
			res.payload_byte = '0;
			res.byte_index   = '0;
			res.last         = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			in_payload_q <= 1'b0;
			remain_q     <= '0;
			pos_q        <= '0;
			sum_q        <= '0;
			len_q        <= '0;
			op_q         <= '0;
		end else if (step) begin
			if (in_payload_q) begin
				if (remain_q != '0) begin
					sum_q    <= sum_q + byte_in;
					pos_q    <= pos_q + 16'd1;
					remain_q <= remain_q - 16'd1;
				end else begin
					in_payload_q <= 1'b0;
					fill_q       <= '0;
				end
			end else if (hdr_done) begin
				if (hdr_ok) begin
					len_q        <= hdr_len;
					op_q         <= hdr_op;
					in_payload_q <= 1'b1;
					remain_q     <= hdr_len;
					pos_q        <= '0;
					sum_q        <= hdr_sum;
					fill_q       <= '0;
				end
			end else begin
				fill_q <= fill_q + 3'd1;
			end
		end
	end

	// The window holds the five oldest header bytes; the sixth is the current word.
	for (genvar g = 0; g < WinDepth; g++) begin : g_win
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				win_q[g] <= '0;
			end else if (step && !in_payload_q) begin
				if (hdr_done) begin
					if (!hdr_ok) begin
						win_q[g] <= (g == WinDepth - 1) ? byte_in : win_q[(g + 1) % WinDepth];
					end
				end else if (fill_q == 3'(g)) begin
					win_q[g] <= byte_in;
				end
			end
		end
	end

endmodule

// File: rtl/slofr_out_reg.sv
module slofr_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  slofr_pkg::result_t din,
	output logic               free,
	slofr_result_if.source     res
);
	import slofr_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= din;
		end
	end

	assign res.valid        = valid_q;
	assign res.kind         = data_q.kind;
	assign res.payload_byte = data_q.payload_byte;
	assign res.byte_index   = data_q.byte_index;
	assign res.frame_opcode = data_q.frame_opcode;
	assign res.frame_length = data_q.frame_length;
	assign res.last         = data_q.last;

endmodule

// File: rtl/sync_length_opcode_frame_receiver_core.sv
// Frame receiver for a byte stream: it hunts for a six-byte header (sync 55 AA, big-endian
// length, big-endian opcode matching an enabled opcode register), sliding one byte on each
// failed header, then emits one word per payload byte and a final word that reports whether
// the trailing checksum byte matched. A byte is taken every clock cycle when the result side
// keeps up; each byte passes through the input register and its result is then presented
// from the output register. The opcode registers are written through the configuration port,
// which is always ready, and should only be changed while no frame is in flight.
module sync_length_opcode_frame_receiver_core #(
	parameter int OPCODE_SLOTS = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	slofr_byte_if.sink     rx,
	slofr_result_if.source res,
	slofr_cfg_if.sink      cfg
);
	import slofr_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_free;
	logic        advance;
	logic        res_valid;
	result_t     res_data;
	opcode_tbl_t tbl;

	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	slofr_cfg #(
		.OPCODE_SLOTS(OPCODE_SLOTS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.tbl    (tbl)
	);

	slofr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_in   (byte_s1),
		.tbl       (tbl),
		.res_valid (res_valid),
		.res       (res_data)
	);

	slofr_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res_valid),
		.din    (res_data),
		.free   (out_free),
		.res    (res)
	);

endmodule

// File: rtl/slofr_checker.sv
module slofr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  res_kind,
	input logic [7:0]  res_payload_byte,
	input logic [15:0] res_byte_index,
	input logic        res_last
);
	import slofr_pkg::*;

	// A frame end word carries the checksum verdict and nothing of the payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_last |-> (res_kind == KIND_SUM_GOOD || res_kind == KIND_SUM_BAD)
			&& res_payload_byte == '0 && res_byte_index == '0)
		else $error("frame end word malformed");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> res_kind == KIND_PAYLOAD)
		else $error("payload word with frame end kind");

	// Payload words of one frame count up by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last ##1 res_valid && !res_last && res_byte_index != '0
			|-> res_byte_index == $past(res_byte_index) + 16'd1)
		else $error("payload index skipped");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_byte_index) && $stable(res_last))
		else $error("stalled result word changed");

endmodule

bind sync_length_opcode_frame_receiver_core slofr_checker u_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_kind         (res.kind),
	.res_payload_byte (res.payload_byte),
	.res_byte_index   (res.byte_index),
	.res_last         (res.last)
);
